### rtl/ekd_pkg.sv
// shared types and constants for the escape key decoder and button mapper
// used by ekd_front, ekd_queue, ekd_back and the top level
package ekd_pkg;

  // field widths
  localparam int unsigned BTN_W  = 12;
  localparam int unsigned CODE_W = 8;

  // decoupling queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // escape byte and its gap keycode
  localparam logic [CODE_W-1:0] ESC_BYTE = 8'h1B;

  // cursor keycodes; up, down, left and right map straight to the d-pad
  localparam logic [CODE_W-1:0] KC_UP    = 8'd200;
  localparam logic [CODE_W-1:0] KC_DOWN  = 8'd201;
  localparam logic [CODE_W-1:0] KC_LEFT  = 8'd202;
  localparam logic [CODE_W-1:0] KC_RIGHT = 8'd203;
  localparam logic [CODE_W-1:0] KC_HOME  = 8'd204;
  localparam logic [CODE_W-1:0] KC_END   = 8'd205;

  // input commands
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_GAP   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  // result key status
  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_KEY   = 2'd1,
    ST_UNREC = 2'd2
  } status_e;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_KEY   = 3'd1,
    OP_UNREC = 3'd2,
    OP_TICK  = 3'd3,
    OP_WRITE = 3'd4
  } op_e;

  // queue word: code is the keycode, or the keymap index on a write
  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] code;
    logic [BTN_W-1:0]  mask;
  } item_t;

endpackage

### rtl/ekd_front.sv
// front part: escape sequence parser that classifies each input word
// depends on ekd_pkg
module ekd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          full_i,
  input  logic [1:0]                    cmd_i,
  input  logic [ekd_pkg::CODE_W-1:0]    key_byte_i,
  input  logic [ekd_pkg::BTN_W-1:0]     mask_operand_i,
  output logic                          push_o,
  output ekd_pkg::item_t                item_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_CSI   = 4'b0100,
    PH_DIGIT = 4'b1000
  } phase_e;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_SIX      = 8'h36;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  // keycode for ESC [ digit ~
  function automatic logic [ekd_pkg::CODE_W-1:0] tilde_code(input logic [2:0] digit);
    logic [ekd_pkg::CODE_W-1:0] code;
    case (digit)
      3'd1:    code = 8'd204;
      3'd2:    code = 8'd209;
      3'd3:    code = 8'd206;
      3'd4:    code = 8'd205;
      3'd5:    code = 8'd207;
      3'd6:    code = 8'd208;
      default: code = '0;
    endcase
    return code;
  endfunction

  phase_e         phase_q, phase_d;
  logic [2:0]     digit_q, digit_d;
  ekd_pkg::op_e   op;
  logic [ekd_pkg::CODE_W-1:0] code;
  logic           accept;

  assign accept = in_valid_i && !full_i;

  // parser next state and classification
  always_comb begin
    phase_d = phase_q;
    digit_d = digit_q;
    op      = ekd_pkg::OP_NONE;
    code    = '0;
    case (ekd_pkg::cmd_e'(cmd_i))
      ekd_pkg::CMD_KEY: begin
        case (phase_q)
          PH_IDLE: begin
            if (key_byte_i == ekd_pkg::ESC_BYTE) begin
              phase_d = PH_ESC;
            end else begin
              op   = ekd_pkg::OP_KEY;
              code = key_byte_i;
            end
          end
          PH_ESC: begin
            if (key_byte_i == CH_LBRACKET) begin
              phase_d = PH_CSI;
            end else begin
              op      = ekd_pkg::OP_UNREC;
              phase_d = PH_IDLE;
            end
          end
          PH_CSI: begin
            phase_d = PH_IDLE;
            op      = ekd_pkg::OP_KEY;
            case (key_byte_i)
              CH_A:    code = ekd_pkg::KC_UP;
              CH_B:    code = ekd_pkg::KC_DOWN;
              CH_C:    code = ekd_pkg::KC_RIGHT;
              CH_D:    code = ekd_pkg::KC_LEFT;
              CH_H:    code = ekd_pkg::KC_HOME;
              CH_F:    code = ekd_pkg::KC_END;
              default: begin
                if (key_byte_i >= CH_ONE && key_byte_i <= CH_SIX) begin
                  op      = ekd_pkg::OP_NONE;
                  digit_d = key_byte_i[2:0];
                  phase_d = PH_DIGIT;
                end else begin
                  op = ekd_pkg::OP_UNREC;
                end
              end
            endcase
          end
          default: begin
            phase_d = PH_IDLE;
            if (key_byte_i == CH_TILDE && tilde_code(digit_q) != '0) begin
              op   = ekd_pkg::OP_KEY;
              code = tilde_code(digit_q);
            end else begin
              op = ekd_pkg::OP_UNREC;
            end
          end
        endcase
      end
      ekd_pkg::CMD_GAP: begin
        phase_d = PH_IDLE;
        case (phase_q)
          PH_IDLE: op = ekd_pkg::OP_NONE;
          PH_ESC: begin
            op   = ekd_pkg::OP_KEY;
            code = ekd_pkg::ESC_BYTE;
          end
          default: op = ekd_pkg::OP_UNREC;
        endcase
      end
      ekd_pkg::CMD_TICK: op = ekd_pkg::OP_TICK;
      default: begin
        op   = ekd_pkg::OP_WRITE;
        code = key_byte_i;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      digit_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
    end
  end

  assign push_o      = accept;
  assign item_o.op   = op;
  assign item_o.code = code;
  assign item_o.mask = mask_operand_i;

`ifndef SYNTHESIS
  // a pending digit is always one of the six editing keys
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGIT |-> digit_q >= 3'd1 && digit_q <= 3'd6)
    else $error("pending digit out of range in digit phase");
`endif

endmodule

### rtl/ekd_queue.sv
// two-entry queue that decouples the parser from the keymap back end
// depends on ekd_pkg
module ekd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ekd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output ekd_pkg::item_t head_o
);

  ekd_pkg::item_t               entries_q [ekd_pkg::Q_DEPTH];
  logic [ekd_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ekd_pkg::Q_CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o       = cnt_q == ekd_pkg::Q_CNT_W'(ekd_pkg::Q_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = entries_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  // no word is written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  // no word is taken from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/ekd_back.sv
// back part: keymap memory lookup, frame masks and the result register
// depends on ekd_pkg
module ekd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  ekd_pkg::item_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 key_status_o,
  output logic [ekd_pkg::CODE_W-1:0] keycode_o,
  output logic [ekd_pkg::BTN_W-1:0]  key_buttons_o,
  output logic [ekd_pkg::BTN_W-1:0]  curr_buttons_o,
  output logic [ekd_pkg::BTN_W-1:0]  prev_buttons_o,
  output logic                       held_o,
  output logic                       pressed_o,
  output logic                       released_o
);

  localparam int unsigned KM_DEPTH = 1 << ekd_pkg::CODE_W;

  // default layout: wasd d-pad, jkl; face buttons, q/e shoulders, enter, bracket
  function automatic logic [ekd_pkg::BTN_W-1:0] keymap_default(
    input logic [ekd_pkg::CODE_W-1:0] addr
  );
    logic [ekd_pkg::BTN_W-1:0] btn;
    case (addr)
      8'h77:   btn = 12'h008; // w
      8'h61:   btn = 12'h002; // a
      8'h73:   btn = 12'h004; // s
      8'h64:   btn = 12'h001; // d
      8'h6A:   btn = 12'h010; // j
      8'h6B:   btn = 12'h020; // k
      8'h6C:   btn = 12'h040; // l
      8'h3B:   btn = 12'h080; // ;
      8'h71:   btn = 12'h100; // q
      8'h65:   btn = 12'h200; // e
      8'h0D:   btn = 12'h400; // carriage return
      8'h5B:   btn = 12'h800; // [
      default: btn = '0;
    endcase
    return btn;
  endfunction

  logic [ekd_pkg::BTN_W-1:0] keymap_mem [KM_DEPTH];
  logic [KM_DEPTH-1:0]       keymap_vld_q;

  // lookup stage
  logic                      a_valid_q, a_valid_d;
  ekd_pkg::item_t            a_item_q;
  logic [ekd_pkg::BTN_W-1:0] a_rdata_q;
  logic                      a_rvld_q;

  // result stage
  logic                       out_valid_q, out_valid_d;
  ekd_pkg::status_e           status_q, status_d;
  logic [ekd_pkg::CODE_W-1:0] keycode_q, keycode_d;
  logic [ekd_pkg::BTN_W-1:0]  key_buttons_q, key_buttons_d;
  logic [ekd_pkg::BTN_W-1:0]  frame_now_q, frame_now_d;
  logic [ekd_pkg::BTN_W-1:0]  frame_before_q, frame_before_d;
  logic                       held_q, held_d, pressed_q, pressed_d;
  logic                       released_q, released_d;

  logic                      load_a, load_out, is_key, query, now_hit, prev_hit;
  logic [ekd_pkg::BTN_W-1:0] lookup, mapped;

  // stage advance
  assign load_out = a_valid_q && (!out_valid_q || !out_stall_i);
  assign load_a   = head_valid_i && (!a_valid_q || load_out);
  assign pop_o    = load_a;

  always_comb begin
    a_valid_d = a_valid_q;
    if (load_a) begin
      a_valid_d = 1'b1;
    end else if (load_out) begin
      a_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // keymap memory: write or registered read as a word enters the lookup stage
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      if (head_i.op == ekd_pkg::OP_WRITE) begin
        keymap_mem[head_i.code] <= head_i.mask;
      end
      a_rdata_q <= keymap_mem[head_i.code];
      a_rvld_q  <= keymap_vld_q[head_i.code];
      a_item_q  <= head_i;
    end
  end

  // entries never written read as the default layout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keymap_vld_q <= '0;
    end else if (load_a && head_i.op == ekd_pkg::OP_WRITE) begin
      keymap_vld_q[head_i.code] <= 1'b1;
    end
  end

  // button mapping
  assign lookup = a_rvld_q ? a_rdata_q : keymap_default(a_item_q.code);
  assign is_key = a_item_q.op == ekd_pkg::OP_KEY;

  always_comb begin
    case (a_item_q.code)
      ekd_pkg::KC_UP:    mapped = 12'h008;
      ekd_pkg::KC_DOWN:  mapped = 12'h004;
      ekd_pkg::KC_LEFT:  mapped = 12'h002;
      ekd_pkg::KC_RIGHT: mapped = 12'h001;
      default:           mapped = lookup;
    endcase
  end

  // frame masks and status
  always_comb begin
    frame_now_d    = frame_now_q;
    frame_before_d = frame_before_q;
    status_d       = ekd_pkg::ST_NONE;
    case (a_item_q.op)
      ekd_pkg::OP_KEY: begin
        status_d    = ekd_pkg::ST_KEY;
        frame_now_d = frame_now_q | mapped;
      end
      ekd_pkg::OP_UNREC: status_d = ekd_pkg::ST_UNREC;
      ekd_pkg::OP_TICK: begin
        frame_before_d = frame_now_q;
        frame_now_d    = '0;
      end
      default: status_d = ekd_pkg::ST_NONE;
    endcase
  end

  // query against the updated masks
  assign query         = a_item_q.op != ekd_pkg::OP_WRITE;
  assign now_hit       = query && |(frame_now_d & a_item_q.mask);
  assign prev_hit      = query && |(frame_before_d & a_item_q.mask);
  assign keycode_d     = is_key ? a_item_q.code : '0;
  assign key_buttons_d = is_key ? mapped : '0;
  assign held_d        = now_hit;
  assign pressed_d     = now_hit && !prev_hit;
  assign released_d    = !now_hit && prev_hit;

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      frame_now_q    <= '0;
      frame_before_q <= '0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        frame_now_q    <= frame_now_d;
        frame_before_q <= frame_before_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q      <= status_d;
      keycode_q     <= keycode_d;
      key_buttons_q <= key_buttons_d;
      held_q        <= held_d;
      pressed_q     <= pressed_d;
      released_q    <= released_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_status_o   = status_q;
  assign keycode_o      = keycode_q;
  assign key_buttons_o  = key_buttons_q;
  assign curr_buttons_o = frame_now_q;
  assign prev_buttons_o = frame_before_q;
  assign held_o         = held_q;
  assign pressed_o      = pressed_q;
  assign released_o     = released_q;

`ifndef SYNTHESIS
  // only a decoded key carries a keycode and buttons
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ekd_pkg::ST_KEY |-> keycode_q == '0 && key_buttons_q == '0)
    else $error("keycode or buttons on a result without a key");
  // a frame tick moves the current mask to the previous one and clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && a_item_q.op == ekd_pkg::OP_TICK
      |=> frame_before_q == $past(frame_now_q) && frame_now_q == '0)
    else $error("frame tick did not shift masks");
  // a query cannot be pressed and released at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(pressed_q && released_q))
    else $error("pressed and released both set");
`endif

endmodule

### rtl/escape_key_decoder_button_mapper_unit.sv
// top level of the escape key decoder and button mapper
// depends on ekd_pkg, ekd_front, ekd_queue and ekd_back
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one word per
// accepted cycle: a key byte, an input gap timeout, a frame tick or a
// keymap write, selected by cmd_i. Every word yields exactly one result
// word on the output channel (out_valid_o / out_stall_i), in order.
// The parser classifies a word as it is accepted and places it in a
// two-entry queue; the back end reads the 256-entry keymap memory with a
// registered read, then updates the frame masks into the result register.
// A word passes the queue, then the lookup stage, then the result register.
// Throughput: one word per cycle while results are not stalled; a keymap
// write is seen by the very next lookup. The single keymap port sets this rate.
// Reset: the parser returns to idle, both frame masks clear and the
// keymap reads as the default layout at once (no clearing pass).
// Stall: a stalled result holds; the lookup stage and queue fill behind
// it, and in_stall_o rises when the queue is full.
module escape_key_decoder_button_mapper_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [ekd_pkg::CODE_W-1:0] key_byte_i,
  input  logic [ekd_pkg::BTN_W-1:0]  mask_operand_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 key_status_o,
  output logic [ekd_pkg::CODE_W-1:0] keycode_o,
  output logic [ekd_pkg::BTN_W-1:0]  key_buttons_o,
  output logic [ekd_pkg::BTN_W-1:0]  curr_buttons_o,
  output logic [ekd_pkg::BTN_W-1:0]  prev_buttons_o,
  output logic                       held_o,
  output logic                       pressed_o,
  output logic                       released_o
);

  logic           push, full, pop, head_valid;
  ekd_pkg::item_t push_item, head_item;

  assign in_stall_o = full;

  // parser and classifier
  ekd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .full_i         (full),
    .cmd_i          (cmd_i),
    .key_byte_i     (key_byte_i),
    .mask_operand_i (mask_operand_i),
    .push_o         (push),
    .item_o         (push_item)
  );

  // decoupling queue
  ekd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_item)
  );

  // keymap and frame back end
  ekd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_status_o   (key_status_o),
    .keycode_o      (keycode_o),
    .key_buttons_o  (key_buttons_o),
    .curr_buttons_o (curr_buttons_o),
    .prev_buttons_o (prev_buttons_o),
    .held_o         (held_o),
    .pressed_o      (pressed_o),
    .released_o     (released_o)
  );

endmodule

### dv/tb_escape_key_decoder_button_mapper_unit.sv
// self-checking testbench for escape_key_decoder_button_mapper_unit
// a directed table then random key sequences, checked against a built-in key decoder model
// depends on ekd_pkg and the rtl top level
module tb_escape_key_decoder_button_mapper_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // editing keycodes with no package constant
  localparam logic [ekd_pkg::CODE_W-1:0] KC_DELETE = 8'd206;
  localparam logic [ekd_pkg::CODE_W-1:0] KC_PGUP   = 8'd207;
  localparam logic [ekd_pkg::CODE_W-1:0] KC_PGDN   = 8'd208;
  localparam logic [ekd_pkg::CODE_W-1:0] KC_INSERT = 8'd209;
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_TILDE    = "~";
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam int unsigned WORD_TARGET = 1075;

  localparam logic [7:0] MAPPED_KEYS [12] =
    '{"w", "a", "s", "d", "j", "k", "l", ";", "q", "e", CH_CR, CH_LBRACKET};
  localparam logic [7:0] CSI_FINALS [6] = '{"A", "B", "C", "D", "H", "F"};

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_ESC   = 2'd1,
    SEQ_CSI   = 2'd2,
    SEQ_DIGIT = 2'd3
  } seq_phase_e;

  typedef struct packed {
    ekd_pkg::status_e           status;
    logic [ekd_pkg::CODE_W-1:0] code;
    logic [ekd_pkg::BTN_W-1:0]  kb;
    logic [ekd_pkg::BTN_W-1:0]  curr;
    logic [ekd_pkg::BTN_W-1:0]  prev;
    logic                       held;
    logic                       pressed;
    logic                       released;
  } key_result_t;

  typedef struct {
    ekd_pkg::cmd_e              cmd;
    logic [ekd_pkg::CODE_W-1:0] b;
    logic [ekd_pkg::BTN_W-1:0]  m;
    bit                         known;
    key_result_t                want;
  } key_word_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [1:0]                   cmd_i;
  logic [ekd_pkg::CODE_W-1:0]   key_byte_i;
  logic [ekd_pkg::BTN_W-1:0]    mask_operand_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [1:0]                   key_status_o;
  logic [ekd_pkg::CODE_W-1:0]   keycode_o;
  logic [ekd_pkg::BTN_W-1:0]    key_buttons_o;
  logic [ekd_pkg::BTN_W-1:0]    curr_buttons_o;
  logic [ekd_pkg::BTN_W-1:0]    prev_buttons_o;
  logic                         held_o;
  logic                         pressed_o;
  logic                         released_o;

  // decoder model state
  logic [ekd_pkg::BTN_W-1:0]    keymap_model [256];
  seq_phase_e                   seq_phase;
  logic [2:0]                   seq_digit;
  logic [ekd_pkg::BTN_W-1:0]    frame_now;
  logic [ekd_pkg::BTN_W-1:0]    frame_prev;

  key_word_t           key_words [$];
  key_result_t         expected_results [$];
  int                  mismatches = 0;
  int                  rx_wait = 0;
  bit                  quiet_run = 0;

  escape_key_decoder_button_mapper_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .key_byte_i     (key_byte_i),
    .mask_operand_i (mask_operand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_status_o   (key_status_o),
    .keycode_o      (keycode_o),
    .key_buttons_o  (key_buttons_o),
    .curr_buttons_o (curr_buttons_o),
    .prev_buttons_o (prev_buttons_o),
    .held_o         (held_o),
    .pressed_o      (pressed_o),
    .released_o     (released_o)
  );

  // decode one word, update frames and keymap, return the result word
  function automatic key_result_t decode_key_word(ekd_pkg::cmd_e c,
                                                  logic [ekd_pkg::CODE_W-1:0] b,
                                                  logic [ekd_pkg::BTN_W-1:0] m);
    key_result_t r;
    ekd_pkg::status_e st;
    logic [ekd_pkg::CODE_W-1:0] code;
    logic [ekd_pkg::BTN_W-1:0] kb;
    logic now_hit;
    logic prev_hit;
    st = ekd_pkg::ST_NONE;
    code = '0;
    kb = '0;
    case (c)
      ekd_pkg::CMD_KEY: begin
        case (seq_phase)
          SEQ_IDLE: begin
            if (b == ekd_pkg::ESC_BYTE) seq_phase = SEQ_ESC;
            else begin
              st = ekd_pkg::ST_KEY;
              code = b;
            end
          end
          SEQ_ESC: begin
            if (b == CH_LBRACKET) seq_phase = SEQ_CSI;
            else begin
              st = ekd_pkg::ST_UNREC;
              seq_phase = SEQ_IDLE;
            end
          end
          SEQ_CSI: begin
            seq_phase = SEQ_IDLE;
            st = ekd_pkg::ST_KEY;
            case (b)
              "A": code = ekd_pkg::KC_UP;
              "B": code = ekd_pkg::KC_DOWN;
              "C": code = ekd_pkg::KC_RIGHT;
              "D": code = ekd_pkg::KC_LEFT;
              "H": code = ekd_pkg::KC_HOME;
              "F": code = ekd_pkg::KC_END;
              default: begin
                st = ekd_pkg::ST_UNREC;
                if (b >= "1" && b <= "6") begin
                  st = ekd_pkg::ST_NONE;
                  seq_digit = 3'(b - "0");
                  seq_phase = SEQ_DIGIT;
                end
              end
            endcase
          end
          default: begin
            // digit seen, only a tilde completes the key
            seq_phase = SEQ_IDLE;
            st = ekd_pkg::ST_UNREC;
            if (b == CH_TILDE) begin
              st = ekd_pkg::ST_KEY;
              case (seq_digit)
                3'd1: code = ekd_pkg::KC_HOME;
                3'd2: code = KC_INSERT;
                3'd3: code = KC_DELETE;
                3'd4: code = ekd_pkg::KC_END;
                3'd5: code = KC_PGUP;
                3'd6: code = KC_PGDN;
                default: st = ekd_pkg::ST_UNREC;
              endcase
            end
          end
        endcase
      end
      ekd_pkg::CMD_GAP: begin
        if (seq_phase == SEQ_ESC) begin
          st = ekd_pkg::ST_KEY;
          code = ekd_pkg::ESC_BYTE;
        end else if (seq_phase != SEQ_IDLE) begin
          st = ekd_pkg::ST_UNREC;
        end
        seq_phase = SEQ_IDLE;
      end
      ekd_pkg::CMD_TICK: begin
        frame_prev = frame_now;
        frame_now = '0;
      end
      default: keymap_model[b] = m;
    endcase

    // d-pad keys bypass the keymap
    if (st == ekd_pkg::ST_KEY) begin
      case (code)
        ekd_pkg::KC_UP:    kb = 12'h008;
        ekd_pkg::KC_DOWN:  kb = 12'h004;
        ekd_pkg::KC_LEFT:  kb = 12'h002;
        ekd_pkg::KC_RIGHT: kb = 12'h001;
        default:           kb = keymap_model[code];
      endcase
      frame_now = frame_now | kb;
    end

    now_hit  = (c != ekd_pkg::CMD_WRITE) && ((frame_now & m) != '0);
    prev_hit = (c != ekd_pkg::CMD_WRITE) && ((frame_prev & m) != '0);
    r.status   = st;
    r.code     = code;
    r.kb       = kb;
    r.curr     = frame_now;
    r.prev     = frame_prev;
    r.held     = now_hit;
    r.pressed  = now_hit && !prev_hit;
    r.released = !now_hit && prev_hit;
    return r;
  endfunction

  function automatic logic [ekd_pkg::BTN_W-1:0] rand_query();
    case ($urandom_range(0, 5))
      0: return 12'hFFF;
      1: return 12'h000;
      2, 3: return 12'h001 << $urandom_range(0, 11);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic add_word(ekd_pkg::cmd_e c, logic [ekd_pkg::CODE_W-1:0] b,
                          logic [ekd_pkg::BTN_W-1:0] m);
    key_word_t w;
    w.cmd = c;
    w.b = b;
    w.m = m;
    w.known = 0;
    w.want = '0;
    key_words.push_back(w);
  endtask

  task automatic add_known(ekd_pkg::cmd_e c, logic [ekd_pkg::CODE_W-1:0] b,
                           logic [ekd_pkg::BTN_W-1:0] m, ekd_pkg::status_e st,
                           logic [ekd_pkg::CODE_W-1:0] code, logic [ekd_pkg::BTN_W-1:0] kb,
                           logic [ekd_pkg::BTN_W-1:0] cur, logic [ekd_pkg::BTN_W-1:0] prv,
                           logic h, logic p, logic r);
    key_word_t w;
    w.cmd = c;
    w.b = b;
    w.m = m;
    w.known = 1;
    w.want = '{st, code, kb, cur, prv, h, p, r};
    key_words.push_back(w);
  endtask

  task automatic add_key(logic [ekd_pkg::CODE_W-1:0] b);
    add_word(ekd_pkg::CMD_KEY, b, rand_query());
  endtask

  // a tick or keymap write now and then inside a sequence
  task automatic maybe_interject();
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 1) add_word(ekd_pkg::CMD_TICK, 8'($urandom), rand_query());
      else add_word(ekd_pkg::CMD_WRITE, MAPPED_KEYS[$urandom_range(0, 11)],
                    12'($urandom_range(0, 4095)));
    end
  endtask

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // result check and output stall
  always @(posedge clk_i) begin : result_check
    key_result_t seen;
    key_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{ekd_pkg::status_e'(key_status_o), keycode_o, key_buttons_o, curr_buttons_o,
               prev_buttons_o, held_o, pressed_o, released_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", seen);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, seen);
        end
      end
      rx_wait = quiet_run ? 0 : $urandom_range(0, 4);
    end
    out_stall_i <= (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  // stimulus, model and end of run
  initial begin : drive
    key_word_t w;
    key_result_t p;
    int gap;
    int pick;
    rst_ni = 0;
    in_valid_i = 0;
    cmd_i = ekd_pkg::CMD_KEY;
    key_byte_i = '0;
    mask_operand_i = '0;

    // default layout of the keymap
    foreach (keymap_model[i]) keymap_model[i] = '0;
    keymap_model["w"] = 12'h008;
    keymap_model["a"] = 12'h002;
    keymap_model["s"] = 12'h004;
    keymap_model["d"] = 12'h001;
    keymap_model["j"] = 12'h010;
    keymap_model["k"] = 12'h020;
    keymap_model["l"] = 12'h040;
    keymap_model[";"] = 12'h080;
    keymap_model["q"] = 12'h100;
    keymap_model["e"] = 12'h200;
    keymap_model[CH_CR] = 12'h400;
    keymap_model[CH_LBRACKET] = 12'h800;
    seq_phase = SEQ_IDLE;
    seq_digit = '0;
    frame_now = '0;
    frame_prev = '0;

    // directed table
    add_known(ekd_pkg::CMD_KEY, "w", 12'h008,
              ekd_pkg::ST_KEY, "w", 12'h008, 12'h008, 12'h000, 1, 1, 0);
    add_known(ekd_pkg::CMD_TICK, 8'h00, 12'h008,
              ekd_pkg::ST_NONE, 8'h00, 12'h000, 12'h000, 12'h008, 0, 0, 1);
    // gap while idle
    add_known(ekd_pkg::CMD_GAP, 8'h00, 12'h000,
              ekd_pkg::ST_NONE, 8'h00, 12'h000, 12'h000, 12'h008, 0, 0, 0);
    // lone escape then gap
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'hFFF);
    add_known(ekd_pkg::CMD_GAP, 8'h00, 12'h000,
              ekd_pkg::ST_KEY, ekd_pkg::ESC_BYTE, 12'h000, 12'h000, 12'h008, 0, 0, 0);
    // tick and keymap write in the middle of a sequence
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'h001);
    add_word(ekd_pkg::CMD_KEY, CH_LBRACKET, 12'h001);
    add_word(ekd_pkg::CMD_TICK, 8'h00, 12'h008);
    add_known(ekd_pkg::CMD_WRITE, 8'hFF, 12'hFFF,
              ekd_pkg::ST_NONE, 8'h00, 12'h000, 12'h000, 12'h000, 0, 0, 0);
    add_word(ekd_pkg::CMD_KEY, "C", 12'h001);
    // unexpected byte after escape
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'h001);
    add_word(ekd_pkg::CMD_KEY, "x", 12'h001);
    // escape inside a sequence
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'hFFF);
    add_word(ekd_pkg::CMD_KEY, CH_LBRACKET, 12'hFFF);
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'hFFF);
    // digit then tilde
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'h001);
    add_word(ekd_pkg::CMD_KEY, CH_LBRACKET, 12'h001);
    add_word(ekd_pkg::CMD_KEY, "2", 12'h001);
    add_word(ekd_pkg::CMD_KEY, CH_TILDE, 12'h001);
    // gap after a digit
    add_word(ekd_pkg::CMD_KEY, ekd_pkg::ESC_BYTE, 12'h000);
    add_word(ekd_pkg::CMD_KEY, CH_LBRACKET, 12'h000);
    add_word(ekd_pkg::CMD_KEY, "5", 12'h000);
    add_word(ekd_pkg::CMD_GAP, 8'hFF, 12'h000);
    // top byte maps through the entry written above
    add_known(ekd_pkg::CMD_KEY, 8'hFF, 12'hFFF,
              ekd_pkg::ST_KEY, 8'hFF, 12'hFFF, 12'hFFF, 12'h000, 1, 1, 0);
    add_known(ekd_pkg::CMD_WRITE, 8'h00, 12'h000,
              ekd_pkg::ST_NONE, 8'h00, 12'h000, 12'hFFF, 12'h000, 0, 0, 0);

    // random part: mostly well-formed sequences, some broken ones and noise
    while (key_words.size() < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if ($urandom_range(0, 4) < 3) add_key(MAPPED_KEYS[$urandom_range(0, 11)]);
        else add_key(8'($urandom));
      end else if (pick < 62) begin
        add_key(ekd_pkg::ESC_BYTE);
        maybe_interject();
        add_key(CH_LBRACKET);
        maybe_interject();
        if (pick < 50) add_key(CSI_FINALS[$urandom_range(0, 5)]);
        else begin
          add_key(8'("0" + $urandom_range(1, 6)));
          maybe_interject();
          add_key(CH_TILDE);
        end
      end else if (pick < 67) begin
        add_key(ekd_pkg::ESC_BYTE);
        add_word(ekd_pkg::CMD_GAP, 8'($urandom), rand_query());
      end else if (pick < 77) begin
        add_word(ekd_pkg::CMD_TICK, 8'($urandom), rand_query());
      end else if (pick < 83) begin
        if ($urandom_range(0, 1) == 1)
          add_word(ekd_pkg::CMD_WRITE, MAPPED_KEYS[$urandom_range(0, 11)],
                   12'($urandom_range(0, 4095)));
        else add_word(ekd_pkg::CMD_WRITE, 8'($urandom), 12'($urandom_range(0, 4095)));
      end else if (pick < 93) begin
        add_key(ekd_pkg::ESC_BYTE);
        case ($urandom_range(0, 5))
          0: add_key(8'($urandom));
          1: begin
            add_key(CH_LBRACKET);
            add_key(8'($urandom));
          end
          2: begin
            add_key(CH_LBRACKET);
            add_key(8'("0" + $urandom_range(1, 6)));
            add_key(8'($urandom));
          end
          3: begin
            add_key(CH_LBRACKET);
            add_word(ekd_pkg::CMD_GAP, 8'($urandom), rand_query());
          end
          4: begin
            add_key(CH_LBRACKET);
            add_key(8'("0" + $urandom_range(0, 9)));
            add_word(ekd_pkg::CMD_GAP, 8'($urandom), rand_query());
          end
          default: add_key(ekd_pkg::ESC_BYTE);
        endcase
      end else begin
        add_word(ekd_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom),
                 12'($urandom_range(0, 4095)));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // send words with random gaps, model each one on acceptance
    while (key_words.size() != 0) begin
      w = key_words.pop_front();
      if ($urandom_range(0, 39) == 0) quiet_run = !quiet_run;
      gap = quiet_run ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1;
      cmd_i <= w.cmd;
      key_byte_i <= w.b;
      mask_operand_i <= w.m;
      do @(posedge clk_i); while (in_stall_o);
      p = decode_key_word(w.cmd, w.b, w.m);
      expected_results.push_back(w.known ? w.want : p);
    end
    in_valid_i <= 0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/ekd_pkg.sv
rtl/ekd_front.sv
rtl/ekd_queue.sv
rtl/ekd_back.sv
rtl/escape_key_decoder_button_mapper_unit.sv
dv/tb_escape_key_decoder_button_mapper_unit.sv
